// ===== rtl/itpp_pkg.sv =====
`default_nettype none

package itpp_pkg;

	// Fixed layout of the packet format.
	localparam logic [15:0] TLV_HEADER_BYTES   = 16'd4;
	localparam logic [15:0] TLV_TYPE_BYTES     = TLV_HEADER_BYTES / 2;
	localparam logic [15:0] FIXED_HEADER_BYTES = 16'd8;

	// Byte positions inside the fixed header.
	localparam logic [15:0] POS_VERSION  = 16'd0;
	localparam logic [15:0] POS_PKT_TYPE = 16'd1;
	localparam logic [15:0] POS_LEN_HI   = 16'd2;
	localparam logic [15:0] POS_LEN_LO   = 16'd3;
	localparam logic [15:0] POS_HDR_LEN  = 16'd7;

	// Parse phases.
	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_FIXED    = 3'd1;
	localparam logic [2:0] PH_SKIP     = 3'd2;
	localparam logic [2:0] PH_NAME_HDR = 3'd3;
	localparam logic [2:0] PH_WALK_HDR = 3'd4;
	localparam logic [2:0] PH_WALK_VAL = 3'd5;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_INT   = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;
	localparam logic [1:0] ST_BAD_NAME  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_EXPECTED_VERSION = 2'd0;
	localparam logic [1:0] REG_INTEREST_TYPE    = 2'd1;
	localparam logic [1:0] REG_NAME_TLV_TYPE    = 2'd2;
	localparam logic [1:0] REG_CHUNK_TLV_TYPE   = 2'd3;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	typedef struct packed {
		logic [7:0]  expected_version;
		logic [7:0]  interest_packet_type;
		logic [15:0] name_tlv_type;
		logic [15:0] chunk_tlv_type;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_start;
		logic       buffer_end;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] packet_length;
		logic [15:0] name_offset;
		logic [15:0] name_length;
		logic [63:0] chunk_number;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/itpp_cfg_regs.sv =====
`default_nettype none

module itpp_cfg_regs
	import itpp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	output cfg_t                        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version     <= 8'd1;
			cfg_q.interest_packet_type <= 8'd0;
			cfg_q.name_tlv_type        <= 16'd0;
			cfg_q.chunk_tlv_type       <= 16'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXPECTED_VERSION: cfg_q.expected_version     <= cfg_wdata[7:0];
				REG_INTEREST_TYPE:    cfg_q.interest_packet_type <= cfg_wdata[7:0];
				REG_NAME_TLV_TYPE:    cfg_q.name_tlv_type        <= cfg_wdata;
				REG_CHUNK_TLV_TYPE:   cfg_q.chunk_tlv_type       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/itpp_parse_core.sv =====
`default_nettype none

module itpp_parse_core
	import itpp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step_en,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output logic       res_valid,
	output result_t    res
);

	logic [2:0]  phase_q,  phase_d;
	logic [15:0] pos_q,    pos_d;
	logic [15:0] plen_q,   plen_d;
	logic [7:0]  hlen_q,   hlen_d;
	logic [15:0] ttype_q,  ttype_d;
	logic [15:0] tlen_q,   tlen_d;
	logic [15:0] left_q,   left_d;
	logic [15:0] nlen_q,   nlen_d;
	logic [63:0] chunk_q,  chunk_d;
	logic        inchk_q,  inchk_d;

	logic [1:0]  st;
	logic        emit;
	logic        stop;
	logic        boundary;
	logic [7:0]  b;

	always_comb begin
		b        = item.data_byte;
		phase_d  = phase_q;
		pos_d    = pos_q;
		plen_d   = plen_q;
		hlen_d   = hlen_q;
		ttype_d  = ttype_q;
		tlen_d   = tlen_q;
		left_d   = left_q;
		nlen_d   = nlen_q;
		chunk_d  = chunk_q;
		inchk_d  = inchk_q;
		emit     = 1'b0;
		stop     = 1'b0;
		boundary = 1'b0;
		st       = ST_OK;

		// A start mark drops whatever packet was in progress.
		if (item.packet_start) begin
			pos_d   = '0;
			plen_d  = '0;
			hlen_d  = '0;
			ttype_d = '0;
			tlen_d  = '0;
			left_d  = '0;
			nlen_d  = '0;
			chunk_d = '0;
			inchk_d = 1'b0;
			phase_d = PH_FIXED;
		end

		case (phase_d)
			PH_IDLE: begin
				stop = 1'b1;
			end
			PH_FIXED: begin
				if ((pos_d == POS_VERSION && b != cfg.expected_version) ||
				    (pos_d == POS_PKT_TYPE && b != cfg.interest_packet_type)) begin
					emit = 1'b1;
					st   = ST_NOT_INT;
					stop = 1'b1;
				end else begin
					if (pos_d == POS_LEN_HI)
						plen_d = {b, 8'h00};
					if (pos_d == POS_LEN_LO)
						plen_d = plen_d | {8'h00, b};
					if (pos_d == POS_HDR_LEN) begin
						hlen_d = b;
						if ({8'h00, b} + TLV_HEADER_BYTES < FIXED_HEADER_BYTES) begin
							emit = 1'b1;
							st   = ST_BAD_NAME;
							stop = 1'b1;
						end else if ({8'h00, b} + TLV_HEADER_BYTES == FIXED_HEADER_BYTES) begin
							phase_d = PH_NAME_HDR;
							left_d  = TLV_HEADER_BYTES;
						end else begin
							phase_d = PH_SKIP;
							left_d  = {8'h00, b} + TLV_HEADER_BYTES - FIXED_HEADER_BYTES;
						end
					end
				end
			end
			PH_SKIP: begin
				left_d = left_d - 16'd1;
				if (left_d == '0) begin
					phase_d = PH_NAME_HDR;
					left_d  = TLV_HEADER_BYTES;
				end
			end
			PH_NAME_HDR, PH_WALK_HDR: begin
				// The first half of a TLV header is the type, the rest the length.
				if (left_d > TLV_TYPE_BYTES)
					ttype_d = {ttype_d[7:0], b};
				else
					tlen_d = {tlen_d[7:0], b};
				left_d = left_d - 16'd1;
				if (left_d == '0) begin
					if (phase_d == PH_NAME_HDR) begin
						if (ttype_d != cfg.name_tlv_type) begin
							emit = 1'b1;
							st   = ST_BAD_NAME;
							stop = 1'b1;
						end else begin
							nlen_d   = tlen_d;
							phase_d  = PH_WALK_HDR;
							left_d   = TLV_HEADER_BYTES;
							boundary = 1'b1;
						end
					end else begin
						if (ttype_d == cfg.chunk_tlv_type) begin
							chunk_d = '0;
							inchk_d = 1'b1;
						end
						if (tlen_d == '0) begin
							inchk_d  = 1'b0;
							left_d   = TLV_HEADER_BYTES;
							boundary = 1'b1;
						end else begin
							phase_d = PH_WALK_VAL;
							left_d  = tlen_d;
						end
					end
				end
			end
			default: begin
				if (inchk_d)
					chunk_d = {chunk_d[55:0], b};
				left_d = left_d - 16'd1;
				if (left_d == '0) begin
					inchk_d  = 1'b0;
					phase_d  = PH_WALK_HDR;
					left_d   = TLV_HEADER_BYTES;
					boundary = 1'b1;
				end
			end
		endcase

		if (!stop) begin
			if (pos_d != 16'hFFFF)
				pos_d = pos_d + 16'd1;
			if (boundary && pos_d >= plen_d) begin
				emit = 1'b1;
				st   = ST_OK;
			end else if (item.buffer_end) begin
				emit = 1'b1;
				st   = ST_TRUNCATED;
			end
		end

		if (emit)
			phase_d = PH_IDLE;

		res.status = st;
		if (st == ST_OK) begin
			res.packet_length = plen_d;
			res.name_offset   = {8'h00, hlen_d} + FIXED_HEADER_BYTES;
			res.name_length   = nlen_d;
			res.chunk_number  = chunk_d;
		end else begin
			res.packet_length = '0;
			res.name_offset   = '0;
			res.name_length   = '0;
			res.chunk_number  = '0;
		end
		res_valid = step_en && emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			plen_q  <= '0;
			hlen_q  <= '0;
			ttype_q <= '0;
			tlen_q  <= '0;
			left_q  <= '0;
			nlen_q  <= '0;
			chunk_q <= '0;
			inchk_q <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			plen_q  <= plen_d;
			hlen_q  <= hlen_d;
			ttype_q <= ttype_d;
			tlen_q  <= tlen_d;
			left_q  <= left_d;
			nlen_q  <= nlen_d;
			chunk_q <= chunk_d;
			inchk_q <= inchk_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/interest_packet_tlv_parser.sv =====
// Path: an accepted byte is held in the input stage, is parsed as it leaves that stage, and a
// result it causes is registered in the result register that drives the output ports.
// Throughput: one byte per cycle, set by the parse step that updates the parse state
// registers; the input side stalls only while a result waits.
// Reset: arst_n is asynchronous and active low; it empties both register stages,
// puts the parser in idle and loads the configuration registers with their defaults.
`default_nettype none

module interest_packet_tlv_parser
	import itpp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   packet_start,
	input  wire logic                   buffer_end,

	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [1:0]                  status,
	output logic [15:0]                 packet_length,
	output logic [15:0]                 name_offset,
	output logic [15:0]                 name_length,
	output logic [63:0]                 chunk_number,

	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    core_res_valid;
	result_t core_res;
	result_t res_q;
	logic    out_valid_q;

	// Configuration registers; the user must write them only while the parser is quiet (not enforced here).
	itpp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The byte in the input stage is parsed whenever the result register is free
	// or is being emptied in this cycle, so a result is never overwritten.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// The input stage is payload only; its valid bit covers it.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.data_byte    <= data_byte;
			item_s1.packet_start <= packet_start;
			item_s1.buffer_end   <= buffer_end;
		end
	end

	// Parse state and the per-byte step.
	itpp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (core_res_valid),
		.res       (core_res)
	);

	// Result register. A new request from the core can land in the same cycle
	// that the previous one is taken by the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res_valid)
			res_q <= core_res;
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q.status;
	assign packet_length = res_q.packet_length;
	assign name_offset   = res_q.name_offset;
	assign name_length   = res_q.name_length;
	assign chunk_number  = res_q.chunk_number;

	// With the result register empty, the input side must be open.
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with an empty result register");

	// A result only ever comes from a byte that was parsed in the cycle before.
	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance))
		else $error("result appeared without a parsed byte");

	// Failed packets report nothing but the status.
	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status != ST_OK) |->
		(res_q.packet_length == '0 && res_q.name_offset == '0 &&
		 res_q.name_length == '0 && res_q.chunk_number == '0))
		else $error("failed result carries nonzero fields");

	// A good packet has its name past the fixed header and a name TLV header.
	a_ok_name_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status == ST_OK) |->
		(res_q.name_offset >= FIXED_HEADER_BYTES + TLV_HEADER_BYTES))
		else $error("good result with a name offset inside the fixed header");

endmodule

`default_nettype wire
